[sv/alpha_trimmed_mean_3x3_defines.svh]
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: assertion macros
// Shared assertion helpers. Each check is sampled on the rising clock edge and
// is switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef ALPHA_TRIMMED_MEAN_3X3_DEFINES_SVH
`define ALPHA_TRIMMED_MEAN_3X3_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atm: next-cycle check failed");

`endif

[sv/atm_pkg.sv]
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: shared package
// Constants and status types used by the sorter, the queue, the mean unit
// and the top level.
// ----------------------------------------------------------------------------
package atm_pkg;

  // Default sample width.
  localparam int SAMPLE_BITS = 8;

  // Window geometry.
  localparam int WIN_SIZE = 9;
  localparam int MID     = (WIN_SIZE - 1) / 2;

  // Trim register.
  localparam int                  TRIM_BITS  = 3;
  localparam int                  MAX_TRIM   = 4;
  localparam logic [TRIM_BITS-1:0] TRIM_RESET = 3'd1;

  // Width of the number of kept samples (at most nine).
  localparam int DIV_W = 4;

  // Depth of the queue between the sorter and the mean unit.
  localparam int QUEUE_DEPTH = 2;

  // Status of the sorting front end.
  typedef struct packed {
    logic busy;
  } atm_front_sts_t;

  // Status of the mean back end.
  typedef struct packed {
    logic busy;
    logic load;
    logic div_ok;
  } atm_back_sts_t;

endpackage

[sv/atm_if.sv]
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: channel interfaces
// Valid/ready channels for the window input, the result output and the
// trim register write port.
// ----------------------------------------------------------------------------

// One 3x3 window per beat.
interface atm_win_if #(
  parameter int W = atm_pkg::SAMPLE_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample_0;
  logic [W-1:0] sample_1;
  logic [W-1:0] sample_2;
  logic [W-1:0] sample_3;
  logic [W-1:0] sample_4;
  logic [W-1:0] sample_5;
  logic [W-1:0] sample_6;
  logic [W-1:0] sample_7;
  logic [W-1:0] sample_8;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8,
    output ready
  );
endinterface

// One trimmed mean per beat.
interface atm_res_if #(
  parameter int W = atm_pkg::SAMPLE_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] trimmed_mean;

  modport source (output valid, trimmed_mean, input ready);
  modport sink   (input valid, trimmed_mean, output ready);
endinterface

// Trim register write port.
interface atm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [atm_pkg::TRIM_BITS-1:0] trim_count;

  modport source (output valid, trim_count, input ready);
  modport sink   (input valid, trim_count, output ready);
endinterface

[sv/alpha_trimmed_mean_3x3.sv]
// Throughput: one window per cycle while the output is not stalled; the sort pipe
// (nine rounds) and the mean pipe (four stages, one sum-by-reciprocal multiply, 12x13
// bits for 8-bit samples) each take a beat every cycle unless the output stalls.
// The two-entry queue between them lets either side stall.
// Reset: asynchronous, active low; clears all valid bits and sets trim_count to 1.
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: top level
// Sorts a 3x3 window, drops trim_count samples from each end and returns the
// floor mean of the rest. A trim above four acts as four (the median).
// ----------------------------------------------------------------------------
`include "alpha_trimmed_mean_3x3_defines.svh"

module alpha_trimmed_mean_3x3 #(
  parameter int SAMPLE_BITS = atm_pkg::SAMPLE_BITS,
  parameter int QUEUE_DEPTH = atm_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  atm_cfg_if.sink   cfg_i,
  atm_win_if.sink   win_i,
  atm_res_if.source res_o
);
  import atm_pkg::*;

  localparam int WIN_W = WIN_SIZE * SAMPLE_BITS;

  logic [TRIM_BITS-1:0]                   trim_q;
  logic [WIN_SIZE-1:0][SAMPLE_BITS-1:0]   win_data;
  logic [WIN_SIZE-1:0][SAMPLE_BITS-1:0]   sorted_data;
  logic [WIN_SIZE-1:0][SAMPLE_BITS-1:0]   queued_data;
  logic                                   sort_valid, sort_ready;
  logic                                   queue_valid, queue_ready;
  atm_front_sts_t                         front_sts;
  atm_back_sts_t                          back_sts;

  // Trim register; a write is always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= TRIM_RESET;
    end else if (cfg_i.valid) begin
      trim_q <= cfg_i.trim_count;
    end
  end

  // Gather the window in row-major order.
  assign win_data = {win_i.sample_8, win_i.sample_7, win_i.sample_6,
                     win_i.sample_5, win_i.sample_4, win_i.sample_3,
                     win_i.sample_2, win_i.sample_1, win_i.sample_0};

  // Front end: sorting network pipe.
  atm_sort #(
    .SB (SAMPLE_BITS)
  ) u_sort (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_i.valid),
    .in_ready_o  (win_i.ready),
    .in_data_i   (win_data),
    .out_valid_o (sort_valid),
    .out_ready_i (sort_ready),
    .out_data_o  (sorted_data),
    .sts_o       (front_sts)
  );

  // Queue of sorted windows.
  atm_fifo #(
    .WIDTH (WIN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sort_valid),
    .in_ready_o  (sort_ready),
    .in_data_i   (sorted_data),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_data_o  (queued_data)
  );

  // Back end: trimmed sum and division.
  atm_mean #(
    .SB (SAMPLE_BITS)
  ) u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trim_i      (trim_q),
    .in_valid_i  (queue_valid),
    .in_ready_o  (queue_ready),
    .in_data_i   (queued_data),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_data_o  (res_o.trimmed_mean),
    .sts_o       (back_sts)
  );

  // An accepted window is inside the sort pipe on the next cycle.
  `ATM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, win_i.valid && win_i.ready, front_sts.busy)

  // The corrected quotient leaves a remainder below the kept count.
  `ATM_ASSERT_SAME(a_div_exact, clk_i, rst_ni, back_sts.load, back_sts.div_ok)

  // A register write lands in the trim register.
  `ATM_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_i.valid && cfg_i.ready, trim_q == $past(cfg_i.trim_count))

endmodule

[sv/atm_sort.sv]
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: sorting front end
// Odd-even transposition sort of the nine samples, one round per pipeline
// stage. The whole pipe advances whenever its last stage can drain.
// ----------------------------------------------------------------------------
module atm_sort #(
  parameter int SB = atm_pkg::SAMPLE_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [atm_pkg::WIN_SIZE-1:0][SB-1:0]     in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [atm_pkg::WIN_SIZE-1:0][SB-1:0]     out_data_o,
  output atm_pkg::atm_front_sts_t                  sts_o
);
  import atm_pkg::*;

  localparam int ROUNDS = WIN_SIZE;

  logic [ROUNDS-1:0]                           valid_q;
  logic [ROUNDS-1:0][WIN_SIZE-1:0][SB-1:0]     stage_q;
  logic [ROUNDS-1:0][WIN_SIZE-1:0][SB-1:0]     round_d;
  logic                                        adv;

  // The pipe moves when its last stage is empty or being taken.
  assign adv        = !valid_q[ROUNDS-1] || out_ready_i;
  assign in_ready_o = adv;

  // One compare-exchange round per stage, even and odd pairs alternating.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    logic [WIN_SIZE-1:0][SB-1:0] src;

    if (r == 0) begin : g_first
      assign src = in_data_i;
    end else begin : g_next
      assign src = stage_q[r-1];
    end

    always_comb begin
      round_d[r] = src;
      for (int j = r % 2; j + 1 < WIN_SIZE; j += 2) begin
        if (src[j] > src[j+1]) begin
          round_d[r][j]   = src[j+1];
          round_d[r][j+1] = src[j];
        end
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[ROUNDS-2:0], in_valid_i};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage_q <= round_d;
    end
  end

  assign out_valid_o = valid_q[ROUNDS-1];
  assign out_data_o  = stage_q[ROUNDS-1];
  assign sts_o.busy  = |valid_q;

endmodule

[sv/atm_fifo.sv]
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: decoupling queue
// Small register queue between the sorter and the mean unit, so that each
// side can stall without holding the other.
// ----------------------------------------------------------------------------
module atm_fifo #(
  parameter int WIDTH = atm_pkg::WIN_SIZE * atm_pkg::SAMPLE_BITS,
  parameter int DEPTH = atm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  import atm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PTR_W-1:0]            wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        push, pop;

  assign in_ready_o  = cnt_q != CNT_W'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

[sv/atm_mean.sv]
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: mean back end
// Sums the kept middle of a sorted window and divides by the number kept,
// using a reciprocal multiply with one correction step. Four stages, the
// last one being the output register.
// ----------------------------------------------------------------------------
module atm_mean #(
  parameter int SB = atm_pkg::SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [atm_pkg::TRIM_BITS-1:0]        trim_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [atm_pkg::WIN_SIZE-1:0][SB-1:0] in_data_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [SB-1:0]                        res_data_o,
  output atm_pkg::atm_back_sts_t               sts_o
);
  import atm_pkg::*;

  localparam int PAIR_W   = SB + 1;
  localparam int SUM_BITS = SB + 4;
  localparam int RECIP_W  = SUM_BITS + 1;
  localparam int PROD_W   = SUM_BITS + RECIP_W;
  localparam int QD_W     = SUM_BITS + DIV_W;

  // Reciprocals floor(2^SUM_BITS / kept) for each possible kept count.
  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((64'd1 << SUM_BITS) / 1);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((64'd1 << SUM_BITS) / 3);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((64'd1 << SUM_BITS) / 5);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'((64'd1 << SUM_BITS) / 7);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((64'd1 << SUM_BITS) / 9);

  logic [3:0] valid_q;
  logic       adv;

  logic [TRIM_BITS-1:0]          trim_sat;
  logic [MID:0][PAIR_W-1:0]      pair_d, pair1_q;
  logic [TRIM_BITS-1:0]          trim1_q;

  logic [SUM_BITS-1:0]           sum_d, sum2_q, sum3_q;
  logic [RECIP_W-1:0]            recip_d, recip2_q;
  logic [DIV_W-1:0]              div_d, div2_q, div3_q;

  logic [PROD_W-1:0]             prod3_q;

  logic [SUM_BITS-1:0]           quot0, rem0, rem1, quot_d;
  logic [QD_W-1:0]               quot_div;
  logic [SB-1:0]                 res_q;

  assign adv        = !valid_q[3] || res_ready_i;
  assign in_ready_o = adv;

  // Stage 1: saturate the trim and form the kept pair sums around the median.
  assign trim_sat = (int'(trim_i) > MAX_TRIM) ? TRIM_BITS'(MAX_TRIM) : trim_i;

  always_comb begin
    pair_d[0] = PAIR_W'(in_data_i[MID]);
    for (int k = 1; k <= MID; k++) begin
      if (int'(trim_sat) + k <= MAX_TRIM) begin
        pair_d[k] = PAIR_W'(in_data_i[MID-k]) + PAIR_W'(in_data_i[MID+k]);
      end else begin
        pair_d[k] = '0;
      end
    end
  end

  // Stage 2: total of the kept samples, the kept count and its reciprocal.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k <= MID; k++) begin
      sum_d = sum_d + SUM_BITS'(pair1_q[k]);
    end
  end

  assign div_d = DIV_W'(WIN_SIZE) - DIV_W'({trim1_q, 1'b0});

  always_comb begin
    case (trim1_q)
      3'd0:    recip_d = RECIP_9;
      3'd1:    recip_d = RECIP_7;
      3'd2:    recip_d = RECIP_5;
      3'd3:    recip_d = RECIP_3;
      default: recip_d = RECIP_1;
    endcase
  end

  // Stage 4: estimated quotient is low by at most one; fix it up.
  assign quot0    = prod3_q[SUM_BITS +: SUM_BITS];
  assign quot_div = QD_W'(quot0) * QD_W'(div3_q);
  assign rem0     = sum3_q - quot_div[SUM_BITS-1:0];

  always_comb begin
    if (rem0 >= SUM_BITS'(div3_q)) begin
      quot_d = quot0 + 1'b1;
      rem1   = rem0 - SUM_BITS'(div3_q);
    end else begin
      quot_d = quot0;
      rem1   = rem0;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[2:0], in_valid_i};
    end
  end

  // Stage payload; stage 3 holds the reciprocal product.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pair1_q  <= pair_d;
      trim1_q  <= trim_sat;
      sum2_q   <= sum_d;
      recip2_q <= recip_d;
      div2_q   <= div_d;
      sum3_q   <= sum2_q;
      div3_q   <= div2_q;
      prod3_q  <= PROD_W'(sum2_q) * PROD_W'(recip2_q);
      res_q    <= quot_d[SB-1:0];
    end
  end

  assign res_valid_o  = valid_q[3];
  assign res_data_o   = res_q;
  assign sts_o.busy   = |valid_q;
  assign sts_o.load   = adv && valid_q[2];
  assign sts_o.div_ok = rem1 < SUM_BITS'(div3_q);

endmodule

[tb/sv/tb_alpha_trimmed_mean_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-trimmed mean 3x3: self-checking testbench
// Sends 3x3 windows through the filter under every trim setting, including
// no trim and trims above four. A local sort-and-average computes each
// expected mean, and every output beat is checked in order. Both sides idle
// and stall at random, and the output side also holds off once for a long
// stretch so that the filter fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_alpha_trimmed_mean_3x3;
  import atm_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TRIM_BITS-1:0] trim_t;
  typedef logic [WIN_SIZE-1:0][SAMPLE_BITS-1:0] window_t;
  typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_BURSTY} pace_e;

  localparam int RESET_CYCLES = 12;
  localparam int NUM_CORNERS  = 8;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 155;
  localparam int PRESS_PHASE  = 2;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  localparam trim_t PHASE_TRIM [NUM_PHASES] = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
                                                 3'd7, 3'd0, 3'd1, 3'd4, 3'd0};
  localparam trim_t CORNER_TRIM [3] = '{TRIM_RESET, 3'd0, 3'd7};

  logic clk_i = 1'b0;
  logic rst_ni;

  atm_cfg_if                    cfg ();
  atm_win_if #(.W(SAMPLE_BITS)) win ();
  atm_res_if #(.W(SAMPLE_BITS)) res ();

  alpha_trimmed_mean_3x3 #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .win_i  (win),
    .res_o  (res)
  );

  // Windows waiting to be sent, and means waiting to come out.
  window_t window_q [$];
  sample_t mean_q [$];

  trim_t   trim_model;
  pace_e   tx_pace;
  pace_e   rx_pace;
  logic    hold_req;
  logic    hold_used;
  int      hold_left;
  int      gap_left;
  int      stall_left;
  int      quiet_cycles;
  int      fail_count;
  logic    offer_next;
  window_t taken_win;
  sample_t want_mean;

  always #4 clk_i = ~clk_i;

  // Sort the window, drop trim samples from each end and take the floor mean.
  function automatic sample_t trimmed_mean_of(window_t w, trim_t trim);
    sample_t     s [WIN_SIZE];
    sample_t     v;
    int          i;
    int          p;
    int          t;
    int          kept;
    int unsigned total;
    for (i = 0; i < WIN_SIZE; i++) s[i] = w[i];
    for (i = 1; i < WIN_SIZE; i++) begin
      v = s[i];
      p = i;
      while (p > 0 && s[p-1] > v) begin
        s[p] = s[p-1];
        p--;
      end
      s[p] = v;
    end
    t = (trim > MAX_TRIM) ? MAX_TRIM : int'(trim);
    kept = WIN_SIZE - 2 * t;
    total = 0;
    for (i = t; i < WIN_SIZE - t; i++) total += s[i];
    return sample_t'(total / kept);
  endfunction

  // Number of idle cycles before the next beat on one side.
  function automatic int draw_wait(pace_e pace);
    case (pace)
      PACE_STEADY: return 0;
      PACE_RANDOM: return $urandom_range(0, 14);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  // Hand-picked windows: flat, ramps, lone outliers, checkerboard and ties.
  function automatic window_t corner_window(int k);
    window_t w;
    int      i;
    case (k)
      0: w = '0;
      1: w = '1;
      2: for (i = 0; i < WIN_SIZE; i++) w[i] = sample_t'(i * 31);
      3: for (i = 0; i < WIN_SIZE; i++) w[i] = sample_t'(255 - i * 29);
      4: begin
        w = '0;
        w[4] = '1;
      end
      5: begin
        w = '1;
        w[0] = '0;
      end
      6: for (i = 0; i < WIN_SIZE; i++) w[i] = (i % 2) ? 8'hAA : 8'h55;
      default: w = {8'd128, 8'd200, 8'd0, 8'd255, 8'd7, 8'd3, 8'd200, 8'd7, 8'd7};
    endcase
    return w;
  endfunction

  // Random windows: uniform, clustered, impulse noise, or coarse levels with ties.
  function automatic window_t random_window();
    window_t w;
    int      shape;
    int      base;
    int      i;
    shape = $urandom_range(0, 3);
    base = $urandom_range(0, 239);
    for (i = 0; i < WIN_SIZE; i++) begin
      case (shape)
        0: w[i] = sample_t'($urandom_range(0, 255));
        1: w[i] = sample_t'(base + $urandom_range(0, 16));
        2: begin
          if ($urandom_range(0, 3) == 0) w[i] = $urandom_range(0, 1) ? '1 : '0;
          else w[i] = sample_t'(base);
        end
        default: w[i] = sample_t'($urandom_range(0, 3) * 85);
      endcase
    end
    return w;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // Write the trim register and track it in the local copy.
  task automatic write_trim(trim_t value);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.trim_count <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    trim_model = value;
  endtask

  // Wait until every window has been sent and every mean has come back.
  task automatic wait_drained();
    do @(negedge clk_i); while (window_q.size() != 0 || win.valid || mean_q.size() != 0);
  endtask

  // Window driver: presents the head of the queue, predicts the mean on each beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer_next = 1'b0;
      if (win.valid && win.ready) begin
        taken_win = window_q.pop_front();
        mean_q = {mean_q, trimmed_mean_of(taken_win, trim_model)};
        gap_left = draw_wait(tx_pace);
      end
      if (win.valid && !win.ready) begin
        offer_next = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (window_q.size() > 0) begin
        offer_next = 1'b1;
      end
      win.valid <= offer_next;
      if (offer_next && !(win.valid && !win.ready)) begin
        {win.sample_8, win.sample_7, win.sample_6, win.sample_5, win.sample_4,
         win.sample_3, win.sample_2, win.sample_1, win.sample_0} <= window_q[0];
      end
    end
  end

  // Long output hold-off, used once to back up the whole pipe.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each beat against the oldest predicted mean.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (mean_q.size() == 0) begin
          note_failure($sformatf("unexpected mean %0d", res.trimmed_mean));
        end else begin
          want_mean = mean_q.pop_front();
          if (res.trimmed_mean !== want_mean) begin
            note_failure($sformatf("trimmed_mean expected %0d actual %0d",
                                   want_mean, res.trimmed_mean));
          end
        end
        stall_left = draw_wait(rx_pace);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      res.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((win.valid && win.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence: corner windows, then random phases under each trim.
  initial begin
    rst_ni = 1'b0;
    cfg.valid = 1'b0;
    cfg.trim_count = '0;
    win.valid = 1'b0;
    {win.sample_8, win.sample_7, win.sample_6, win.sample_5, win.sample_4,
     win.sample_3, win.sample_2, win.sample_1, win.sample_0} = '0;
    res.ready = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    fail_count = 0;
    tx_pace = PACE_STEADY;
    rx_pace = PACE_STEADY;
    trim_model = TRIM_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corner windows at the reset trim, with no trim, and with a trim above four.
    for (int k = 0; k < 3; k++) begin
      if (k > 0) write_trim(CORNER_TRIM[k]);
      @(negedge clk_i);
      for (int c = 0; c < NUM_CORNERS; c++) window_q = {window_q, corner_window(c)};
      wait_drained();
    end

    // Random phases, each with its own trim and pacing on both sides.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_trim(PHASE_TRIM[p]);
      @(negedge clk_i);
      tx_pace = pace_e'(p % 3);
      rx_pace = pace_e'((p + 1) % 3);
      if (p == PRESS_PHASE) begin
        tx_pace = PACE_STEADY;
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) window_q = {window_q, random_window()};
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mean_q.size() != 0) begin
      note_failure($sformatf("%0d means never arrived", mean_q.size()));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[alpha_trimmed_mean_3x3.f]
+incdir+sv
sv/atm_pkg.sv
sv/atm_if.sv
sv/atm_sort.sv
sv/atm_fifo.sv
sv/atm_mean.sv
sv/alpha_trimmed_mean_3x3.sv
tb/sv/tb_alpha_trimmed_mean_3x3.sv
